// ----- rtl/gedr_pkg.sv -----
// shared types, constants and tables for the dead-reckoning locator
// no dependencies

package gedr_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int POS_WIDTH_DEF      = 48;

  // angles are Q16.16 degrees, one turn = 360 * 2^16
  localparam int ANG_W        = 25;
  localparam int TURN         = 23592960;
  localparam int HALF_TURN    = 11796480;
  localparam int QUARTER_TURN = 5898240;
  localparam int GAIN_Q30     = 652032874;
  localparam int CORDIC_STEPS = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DEADBAND = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SCALE   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_ANGLE   = 8'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRED,
    ST_GMUL,
    ST_GUPD,
    ST_EANG,
    ST_CORD,
    ST_PROD,
    ST_SCAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    state_t     st;
    logic [5:0] cnt;
    logic       load;
    logic       done;
  } dp_cmd_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [21:0] atan_q16(input logic [3:0] i);
    logic [21:0] v;
    case (i)
      4'd0:    v = 22'd2949120;
      4'd1:    v = 22'd1740967;
      4'd2:    v = 22'd919879;
      4'd3:    v = 22'd466945;
      4'd4:    v = 22'd234379;
      4'd5:    v = 22'd117304;
      4'd6:    v = 22'd58666;
      4'd7:    v = 22'd29335;
      4'd8:    v = 22'd14668;
      4'd9:    v = 22'd7334;
      4'd10:   v = 22'd3667;
      4'd11:   v = 22'd1833;
      4'd12:   v = 22'd917;
      4'd13:   v = 22'd458;
      4'd14:   v = 22'd229;
      4'd15:   v = 22'd115;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/gyro_encoder_dead_reckoning.sv -----
// top level of the gyro and wheel encoder dead-reckoning locator
// depends on gedr_pkg, gedr_ctrl, gedr_dp
//
// input stream s_*: one request per gyro sample (s_tuser 0) or encoder
//   delta pair (s_tuser 1); each request returns one pose on m_*
// config channel cfg_*: register index and data, always ready; write only
//   while no request is in flight
// a gyro request takes 36 cycles: one step to reduce the corrected rate
//   modulo one turn, 32 steps of a shift-add modular multiply by
//   gyro_scale, one heading update, one result cycle and the idle cycle
// an encoder request takes 29 cycles: angle fold, 16 cordic steps,
//   4 cycles on the shared trig multiplier, 6 cycles of wheel scaling and
//   saturating accumulation, one result cycle and the idle cycle
// one request is worked on at a time; s_tready is high only when idle
// the pose goes to an output register; a stalled receiver holds m_tvalid
//   and m_tdata, and the next request may run while the result waits
// reset (synchronous, active high) clears pose, heading and registers

module gyro_encoder_dead_reckoning import gedr_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int POS_WIDTH      = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // rate_sample, count_p, count_q
  input  logic                  s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [((2*POS_WIDTH+ANG_W+7)/8)*8-1:0] m_tdata, // pose_x, pose_y, heading
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  gedr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  gedr_dp #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .POS_WIDTH      (POS_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .out_data  (m_tdata)
  );

endmodule

// ----- rtl/gedr_ctrl.sv -----
// sequencer for the dead-reckoning locator: state, step counter, handshakes
// depends on gedr_pkg

module gedr_ctrl import gedr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    s_tuser,
  output logic    m_tvalid,
  input  logic    m_tready,
  output dp_cmd_t cmd
);

  state_t     state;
  state_t     state_next;
  logic [5:0] cnt;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = s_tuser ? ST_EANG : ST_GRED;
      ST_GRED: state_next = ST_GMUL;
      ST_GMUL: if (cnt == 6'd31) state_next = ST_GUPD;
      ST_GUPD: state_next = ST_DONE;
      ST_EANG: state_next = ST_CORD;
      ST_CORD: if (cnt == 6'(CORDIC_STEPS - 1)) state_next = ST_PROD;
      ST_PROD: if (cnt == 6'd3) state_next = ST_SCAL;
      ST_SCAL: if (cnt == 6'd5) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    cmd.st   = state;
    cmd.cnt  = cnt;
    cmd.load = (state == ST_IDLE) && s_tvalid;
    cmd.done = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 6'd0 : cnt + 6'd1;
      if (cmd.done) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> m_tvalid) else $error("result not presented after done");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_GRED || state == ST_EANG))
    else $error("accepted request did not start work");
  a_cord_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CORD |-> cnt < 6'(CORDIC_STEPS)) else $error("cordic overrun");
`endif

endmodule

// ----- rtl/gedr_dp.sv -----
// datapath of the dead-reckoning locator: registers, residue unit, cordic,
// shared multiplier and saturating accumulators; depends on gedr_pkg

module gedr_dp import gedr_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int POS_WIDTH      = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [63:0]           s_tdata,
  input  dp_cmd_t               cmd,
  output logic [((2*POS_WIDTH+ANG_W+7)/8)*8-1:0] out_data
);

  localparam int OUT_W = ((2*POS_WIDTH+ANG_W+7)/8)*8;
  localparam int TW    = TRIG_FRAC_BITS + 3;
  localparam int PRW   = 17 + TW;
  localparam int AXW   = PRW + 1;
  localparam int PW2   = AXW + 32;
  localparam int SW    = PW2 + 2;
  localparam logic signed [TW-1:0] X0 =
    TW'((GAIN_Q30 + (1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
  localparam logic signed [26:0] TURN_S    = 27'(TURN);
  localparam logic signed [26:0] HALF_S    = 27'(HALF_TURN);
  localparam logic signed [26:0] QUARTER_S = 27'(QUARTER_TURN);
  localparam logic signed [SW-1:0] POS_MAX =
    $signed({{(SW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] POS_MIN = -POS_MAX - SW'(1);
  // one turn is 45 * 2^19; ceil(2^20 / 45) gives the exact quotient below 2^13
  localparam logic [14:0] TURN_RECIP = 15'd23302;

  // configuration
  logic signed [31:0] goff;
  logic [30:0]        dband;
  logic [31:0]        gscale;
  logic [31:0]        wscale;
  logic signed [24:0] mount;

  // item and working registers
  logic [32:0]            mag_r;
  logic                   neg_r;
  logic signed [16:0]     np;
  logic signed [16:0]     qv;
  logic [24:0]            r;
  logic [24:0]            mm;
  logic signed [24:0]     h;
  logic signed [TW-1:0]   x;
  logic signed [TW-1:0]   y;
  logic signed [24:0]     z;
  logic                   flip;
  logic signed [AXW-1:0]  ax;
  logic signed [AXW-1:0]  ay;
  logic [PW2-1:0]         pacc;
  logic signed [POS_WIDTH-1:0] px;
  logic signed [POS_WIDTH-1:0] py;

  // combinational
  logic signed [32:0] corr;
  logic [27:0]        rprod;
  logic [7:0]         rq;
  logic [5:0]         rrem;
  logic [24:0]        radd;
  logic [26:0]        rsum;
  logic [24:0]        rred;
  logic signed [26:0] hs;
  logic signed [26:0] hw;
  logic signed [26:0] mang;
  logic signed [26:0] ang;
  logic signed [26:0] za;
  logic               fa;
  logic signed [TW-1:0] sx;
  logic signed [TW-1:0] sy;
  logic signed [24:0]   at;
  logic signed [TW-1:0] cc;
  logic signed [TW-1:0] ss;
  logic signed [16:0]   mul_a;
  logic signed [TW-1:0] mul_b;
  logic signed [PRW-1:0] prod;
  logic signed [AXW-1:0] axis;
  logic [AXW-1:0]        amag;
  logic [15:0]           wpart;
  logic [AXW+15:0]       mprod;
  logic [PW2-1:0]        inc;
  logic signed [SW-1:0]  acc_s;
  logic signed [SW-1:0]  sum_s;
  logic signed [POS_WIDTH-1:0] sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      goff   <= '0;
      dband  <= '0;
      gscale <= '0;
      wscale <= '0;
      mount  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GYRO_OFFSET:   goff   <= cfg_data;
        REG_RATE_DEADBAND: dband  <= cfg_data[30:0];
        REG_GYRO_SCALE:    gscale <= cfg_data;
        REG_WHEEL_SCALE:   wscale <= cfg_data;
        REG_MOUNT_ANGLE:   mount  <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    corr = $signed({goff[31], goff}) - $signed({s_tdata[31], s_tdata[31:0]});

    // rate magnitude mod one turn: low 19 bits pass, the upper part is reduced
    // mod 45 by reciprocal multiply (magnitude stays below 2^32)
    rprod = 28'(mag_r[31:19]) * 28'(TURN_RECIP);
    rq    = 8'(rprod >> 20);
    rrem  = 6'(mag_r[31:19] - 13'(rq) * 13'd45);

    // modular multiply step: r <- (2r + add) mod turn
    radd = gscale[5'd31 - cmd.cnt[4:0]] ? mm : 25'd0;
    rsum = {1'b0, r, 1'b0} + {2'b0, radd};
    if (rsum >= 27'(2 * TURN)) rred = 25'(rsum - 27'(2 * TURN));
    else if (rsum >= 27'(TURN)) rred = 25'(rsum - 27'(TURN));
    else rred = rsum[24:0];

    // heading update, wrapped into (-180,180]
    hs = neg_r ? (27'(h) - $signed({2'b0, r})) : (27'(h) + $signed({2'b0, r}));
    hw = hs;
    if (neg_r && hs <= -HALF_S) hw = hs + TURN_S;
    else if (!neg_r && hs > HALF_S) hw = hs - TURN_S;

    // rotation angle and quadrant fold
    mang = mount[24] ? (27'(mount) + TURN_S) : 27'(mount);
    ang  = 27'(h) + mang;
    if (ang > HALF_S) ang = ang - TURN_S;
    fa = 1'b1;
    if (ang > QUARTER_S) za = ang - HALF_S;
    else if (ang < -QUARTER_S) za = ang + HALF_S;
    else begin
      za = ang;
      fa = 1'b0;
    end

    sx = x >>> cmd.cnt[3:0];
    sy = y >>> cmd.cnt[3:0];
    at = $signed({3'b0, atan_q16(cmd.cnt[3:0])});

    cc = flip ? -x : x;
    ss = flip ? -y : y;
    mul_a = cmd.cnt[0] ? qv : np;
    mul_b = (cmd.cnt[1:0] == 2'd0 || cmd.cnt[1:0] == 2'd3) ? cc : ss;
    prod  = mul_a * mul_b;

    axis  = (cmd.cnt < 6'd3) ? ax : ay;
    amag  = axis[AXW-1] ? AXW'(-axis) : AXW'(axis);
    wpart = (cmd.cnt == 6'd0 || cmd.cnt == 6'd3) ? wscale[15:0] : wscale[31:16];
    mprod = amag * wpart;

    inc   = pacc >> TRIG_FRAC_BITS;
    acc_s = (cmd.cnt < 6'd3) ? SW'(px) : SW'(py);
    sum_s = axis[AXW-1] ? (acc_s - $signed({2'b0, inc})) : (acc_s + $signed({2'b0, inc}));
    if (sum_s > POS_MAX) sat = POS_WIDTH'(POS_MAX);
    else if (sum_s < POS_MIN) sat = POS_WIDTH'(POS_MIN);
    else sat = POS_WIDTH'(sum_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h  <= '0;
      px <= '0;
      py <= '0;
    end else begin
      if (cmd.st == ST_GUPD && mag_r >= {2'b0, dband}) h <= 25'(hw);
      if (cmd.st == ST_SCAL && cmd.cnt == 6'd2) px <= sat;
      if (cmd.st == ST_SCAL && cmd.cnt == 6'd5) py <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= corr[32];
      mag_r <= corr[32] ? 33'(-corr) : 33'(corr);
      np    <= -17'($signed(s_tdata[47:32]));
      qv    <= 17'($signed(s_tdata[63:48]));
      r     <= '0;
    end
    case (cmd.st)
      ST_GRED: begin
        mm <= {rrem, mag_r[18:0]};
        r  <= '0;
      end
      ST_GMUL: r <= rred;
      ST_EANG: begin
        z    <= 25'(za);
        flip <= fa;
        x    <= X0;
        y    <= '0;
      end
      ST_CORD: begin
        if (!z[24]) begin
          x <= x - sy;
          y <= y + sx;
          z <= z - at;
        end else begin
          x <= x + sy;
          y <= y - sx;
          z <= z + at;
        end
      end
      ST_PROD: begin
        case (cmd.cnt[1:0])
          2'd0:    ax <= AXW'(prod);
          2'd1:    ax <= ax - AXW'(prod);
          2'd2:    ay <= AXW'(prod);
          default: ay <= ay + AXW'(prod);
        endcase
      end
      ST_SCAL: begin
        if (cmd.cnt == 6'd0 || cmd.cnt == 6'd3) pacc <= PW2'(mprod);
        else if (cmd.cnt == 6'd1 || cmd.cnt == 6'd4) pacc <= pacc + (PW2'(mprod) << 16);
      end
      default: ;
    endcase
    if (cmd.done) out_data <= OUT_W'({h, py, px});
  end

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    cmd.st == ST_DONE |-> (27'(h) > -HALF_S && 27'(h) <= HALF_S))
    else $error("heading out of range");
`endif

endmodule

// ----- tb/sv/gyro_encoder_dead_reckoning_test.sv -----
// self-checking bench for the gyro/encoder dead-reckoning locator
// depends on gedr_pkg and gyro_encoder_dead_reckoning; carries its own pose predictor
// and drives random stalls on both streams

module gyro_encoder_dead_reckoning_test;
  import gedr_pkg::*;

  localparam int  TFB      = 15;
  localparam int  PW       = 48;
  localparam int  MW       = ((2*PW+ANG_W+7)/8)*8;
  localparam int  WD_LIMIT = 8000;
  localparam int  SETTLE   = 40;    // slightly more than one gyro request
  localparam int  HOLD_LEN = 600;
  localparam longint POS_MAX = (64'sd1 <<< (PW-1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd5;

  typedef enum bit {KIND_GYRO = 1'b0, KIND_ENC = 1'b1} kind_e;

  typedef struct {
    kind_e       kind;
    bit [31:0]   rate;
    bit [15:0]   cnt_p;
    bit [15:0]   cnt_q;
  } odo_req_t;

  typedef struct {
    bit [PW-1:0]    x;
    bit [PW-1:0]    y;
    bit [ANG_W-1:0] hdg;
  } pose_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [MW-1:0]     m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gyro_encoder_dead_reckoning uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pending requests for the driver, poses still owed by the block
  odo_req_t pending_reqs[$];
  pose_t    pose_queue[$];

  // predictor state and register copies
  longint   hdg_q16, x_pos, y_pos;
  bit [31:0] gyro_ofs, gyro_gain, wheel_gain;
  bit [30:0] dead_band;
  bit [24:0] mount_ofs;

  int       send_idle_pct, recv_stall_pct;
  int       hold_left;
  bit       req_taken;
  int       mismatches;
  int       quiet_cycles;

  longint atan_lut[CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  function automatic longint wrap_turn(longint r);
    r = r % TURN;
    if (r > HALF_TURN) r -= TURN;
    return r;
  endfunction

  // rotation-mode cordic; >>> on signed values rounds toward minus infinity
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    flip = 1'b0;
    z = ang;
    if (z > QUARTER_TURN) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    x = (longint'(GAIN_Q30) + (64'sd1 <<< (29-TFB))) >>> (30-TFB);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_lut[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // scale by wheel gain (truncated toward zero) and add with clamping
  function automatic longint move_axis(longint acc, longint a);
    bit         neg;
    bit [127:0] ua, prod;
    longint     mag, sum;
    neg  = a < 0;
    ua   = neg ? 128'(-a) : 128'(a);
    prod = ua * {96'b0, wheel_gain};
    mag  = longint'(prod >> TFB);
    sum  = neg ? acc - mag : acc + mag;
    if (sum > POS_MAX) sum = POS_MAX;
    if (sum < POS_MIN) sum = POS_MIN;
    return sum;
  endfunction

  function automatic pose_t advance_pose(odo_req_t r);
    longint corr, mag, d, m, ang, c, s, np, q;
    pose_t  p;
    if (r.kind == KIND_GYRO) begin
      corr = longint'($signed(gyro_ofs)) - longint'($signed(r.rate));
      mag  = corr < 0 ? -corr : corr;
      if (mag >= longint'(dead_band)) begin
        d = ((mag % TURN) * (longint'(gyro_gain) % TURN)) % TURN;
        if (corr < 0) d = (TURN - d) % TURN;
        hdg_q16 = wrap_turn(hdg_q16 + TURN + d);
      end
    end else begin
      m = longint'($signed(mount_ofs)) % TURN;
      if (m < 0) m += TURN;
      ang = wrap_turn(hdg_q16 + TURN + m);
      sin_cos(ang, c, s);
      np = -longint'($signed(r.cnt_p));
      q  = longint'($signed(r.cnt_q));
      x_pos = move_axis(x_pos, np * c - q * s);
      y_pos = move_axis(y_pos, np * s + q * c);
    end
    p.x   = x_pos[PW-1:0];
    p.y   = y_pos[PW-1:0];
    p.hdg = hdg_q16[ANG_W-1:0];
    return p;
  endfunction

  // ---------------- input driver ----------------
  // a request is taken at the rising edge; the next one is offered at the falling edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pose_queue.push_back(advance_pose(pending_reqs.pop_front()));
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!(s_tvalid && !req_taken)) begin
      req_taken = 1'b0;
      if (!rst && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser  <= pending_reqs[0].kind;
        // rate_sample, count_p, count_q from bit 0 up
        s_tdata  <= {pending_reqs[0].cnt_q, pending_reqs[0].cnt_p, pending_reqs[0].rate};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- output monitor ----------------
  // long hold-off counted here, separate from the random stalls
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk) begin
    if (rst || hold_left > 0) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    pose_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose %h", m_tdata);
      end else begin
        want = pose_queue.pop_front();
        if (m_tdata[PW-1:0] !== want.x || m_tdata[2*PW-1:PW] !== want.y ||
            m_tdata[2*PW+ANG_W-1:2*PW] !== want.hdg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose x %h y %h hdg %h, got x %h y %h hdg %h",
                     want.x, want.y, want.hdg, m_tdata[PW-1:0], m_tdata[2*PW-1:PW],
                     m_tdata[2*PW+ANG_W-1:2*PW]);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WD_LIMIT) begin
      $display("gyro_encoder_dead_reckoning: mismatch");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------- stimulus ----------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GYRO_OFFSET:   gyro_ofs   = val;
      REG_RATE_DEADBAND: dead_band  = val[30:0];
      REG_GYRO_SCALE:    gyro_gain  = val;
      REG_WHEEL_SCALE:   wheel_gain = val;
      REG_MOUNT_ANGLE:   mount_ofs  = val[24:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(bit [31:0] ofs, bit [31:0] band, bit [31:0] gg, bit [31:0] wg,
                          bit [31:0] mnt);
    write_reg(REG_GYRO_OFFSET, ofs);
    write_reg(REG_RATE_DEADBAND, band);
    write_reg(REG_GYRO_SCALE, gg);
    write_reg(REG_WHEEL_SCALE, wg);
    write_reg(REG_MOUNT_ANGLE, mnt);
  endtask

  // sender waits until every owed pose is back, then the block settles
  task automatic drain();
    wait (pending_reqs.size() == 0 && pose_queue.size() == 0 && !s_tvalid);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_gyro(bit [31:0] rate);
    odo_req_t r;
    r.kind = KIND_GYRO;
    r.rate = rate;
    r.cnt_p = 16'($urandom);
    r.cnt_q = 16'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic add_enc(bit [15:0] cp, bit [15:0] cq);
    odo_req_t r;
    r.kind = KIND_ENC;
    r.rate = $urandom;
    r.cnt_p = cp;
    r.cnt_q = cq;
    pending_reqs.push_back(r);
  endtask

  // mostly small, plausible motion; some full-range values for bit coverage
  task automatic add_random_req();
    int sel;
    sel = $urandom_range(9);
    if ($urandom_range(1)) begin
      if (sel < 7) add_gyro(gyro_ofs - 32'($signed($urandom_range(400)) - 200));
      else add_gyro($urandom);
    end else begin
      if (sel < 7)
        add_enc(16'($signed($urandom_range(600)) - 300),
                16'($signed($urandom_range(600)) - 300));
      else add_enc(16'($urandom), 16'($urandom));
    end
  endtask

  function automatic bit [31:0] pick_mount();
    case ($urandom_range(3))
      0: return 32'(-HALF_TURN);
      1: return 32'(HALF_TURN);
      2: return 32'($urandom_range(2*HALF_TURN) - HALF_TURN);
      default: return {7'b0, 25'($urandom)};   // any 25-bit value, reduced modulo a turn
    endcase
  endfunction

  initial begin
    hdg_q16 = 0; x_pos = 0; y_pos = 0;
    gyro_ofs = 0; dead_band = 0; gyro_gain = 0; wheel_gain = 0; mount_ofs = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_left = 0; req_taken = 1'b0; mismatches = 0; quiet_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one degree per count, unit wheel gain, deadband 100
    set_regs(32'd0, 32'd100, 32'd65536, 32'd65536, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);   // unknown index, no effect
    add_gyro(-32'sd90);                       // below the deadband, ignored
    add_enc(16'sd100, 16'sd0);
    add_gyro(-32'sd100);                      // magnitude at the deadband
    add_gyro(32'sd99);                        // just below, ignored
    add_gyro(-32'sd90);
    add_gyro(32'sd180);
    add_gyro(32'h8000_0000);
    add_gyro(32'h7FFF_FFFF);
    add_gyro(32'd0);
    add_enc(16'h7FFF, 16'h8000);
    add_enc(16'h8000, 16'h7FFF);
    add_enc(16'h8000, 16'h8000);
    add_enc(16'h7FFF, 16'h7FFF);
    add_enc(16'd0, 16'd0);
    drain();
    // extremes: full gains drive both axes into saturation, deadband zero
    set_regs(32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'(HALF_TURN));
    add_gyro(32'h7FFF_FFFF);                  // zero corrected rate, still integrated
    add_enc(16'h8000, 16'h7FFF);
    add_enc(16'h8000, 16'h8000);
    add_gyro(32'h8000_0000);
    add_enc(16'h7FFF, 16'h8000);
    add_enc(16'h7FFF, 16'h7FFF);
    drain();
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'(-HALF_TURN));
    add_gyro(32'h7FFF_FFFF);
    add_gyro(32'h0000_0001);
    add_enc(16'h8000, 16'h0001);
    drain();

    // random phases, cycling through the idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      set_regs($urandom_range(1) ? $urandom : 32'($signed($urandom_range(2000)) - 1000),
               $urandom_range(3) == 0 ? {1'b0, 31'($urandom)} : 32'($urandom_range(150)),
               $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1 << 20)),
               $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1 << 17)),
               pick_mount());
      // receiver holds off while the sender keeps offering
      if (ph == 1) hold_left = HOLD_LEN;
      for (int k = 0; k < 105; k++) add_random_req();
      drain();
    end

    if (mismatches == 0)
      $display("gyro_encoder_dead_reckoning: match");
    else
      $display("gyro_encoder_dead_reckoning: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gedr_pkg.sv
rtl/gedr_ctrl.sv
rtl/gedr_dp.sv
rtl/gyro_encoder_dead_reckoning.sv
tb/sv/gyro_encoder_dead_reckoning_test.sv
